### rtl/lap_stopwatch_with_average_macros.svh
// Assertion macros used by the lap stopwatch datapath.
`ifndef LAP_STOPWATCH_WITH_AVERAGE_MACROS_SVH
`define LAP_STOPWATCH_WITH_AVERAGE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LSA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define LSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/lsa_pkg.sv
// Package with the field widths, codes and control types of the lap stopwatch.
`timescale 1ns / 1ps
`default_nettype none

package lsa_pkg;

    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK    = 3'd0,
        FN_START   = 3'd1,
        FN_STOP    = 3'd2,
        FN_SELECT  = 3'd3,
        FN_CLEAR   = 3'd4,
        FN_AVERAGE = 3'd5,
        FN_READ    = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_BAD_SLOT = 2'd2,
        ST_NO_DATA  = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic rd_capture;
        logic walk;
        logic div_step;
        logic div_finish;
        logic load_out;
    } lsa_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        func_t func;
        logic  in_range;
        logic  any_valid;
        logic  walk_done;
        logic  div_done;
        logic  out_free;
    } lsa_stat_t;

endpackage

`default_nettype wire

### rtl/lsa_if.sv
// Valid/ready channel interfaces for the command and response words.
`timescale 1ns / 1ps
`default_nettype none

interface lsa_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [lsa_pkg::FUNC_W-1:0] func;
    logic [lsa_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output func, output slot, input ready);
    modport sink   (input valid, input func, input slot, output ready);
endinterface

interface lsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lsa_pkg::STATUS_W-1:0] status;
    logic [lsa_pkg::SLOT_W-1:0]   slot_out;
    logic                         entry_valid;
    logic [lsa_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output status, output slot_out, output entry_valid,
                    output value, input ready);
    modport sink   (input valid, input status, input slot_out, input entry_valid,
                    input value, output ready);
endinterface

`default_nettype wire

### rtl/lsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/lsa_ctrl.sv
// Controller state machine that sequences each command word through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module lsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  lsa_pkg::lsa_stat_t stat,
    output lsa_pkg::lsa_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_RDATA = 6'b000100,
        S_WALK  = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (stat.func)
                    lsa_pkg::FN_SELECT, lsa_pkg::FN_READ:
                        state_next = stat.in_range ? S_RDATA : S_EMIT;
                    lsa_pkg::FN_AVERAGE:
                        state_next = stat.any_valid ? S_WALK : S_EMIT;
                    default:
                        state_next = S_EMIT;
                endcase
            end
            S_RDATA:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_EMIT;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_finish = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/lsa_dp.sv
// Datapath: counters, lap memory, averaging walk, serial divider and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "lap_stopwatch_with_average_macros.svh"

module lsa_dp #(
    parameter int SLOTS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsa_pkg::lsa_cmd_t            cmd,
    output lsa_pkg::lsa_stat_t           stat,
    input  logic [lsa_pkg::FUNC_W-1:0]   func,
    input  logic [lsa_pkg::SLOT_W-1:0]   slot,
    input  logic                         rsp_ready,
    output logic                         rsp_valid,
    output logic [lsa_pkg::STATUS_W-1:0] rsp_status,
    output logic [lsa_pkg::SLOT_W-1:0]   rsp_slot_out,
    output logic                         rsp_entry_valid,
    output logic [lsa_pkg::VALUE_W-1:0]  rsp_value
);

    localparam int VW  = lsa_pkg::VALUE_W;
    localparam int SLW = lsa_pkg::SLOT_W;
    localparam int AW  = $clog2(SLOTS);
    localparam int IW  = $clog2(SLOTS + 1);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int SW  = VW + $clog2(SLOTS);
    localparam int DCW = $clog2(SW + 1);

    // Control state, cleared by reset.
    logic [VW-1:0]    now_reg,   now_next;
    logic [VW-1:0]    start_reg, start_next;
    logic             running_reg, running_next;
    logic [AW-1:0]    ptr_reg,   ptr_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic             out_valid_reg, out_valid_next;

    // Payload and working registers.
    lsa_pkg::func_t   func_reg, func_next;
    logic [SLW-1:0]   slot_reg, slot_next;
    lsa_pkg::status_t res_status_reg, res_status_next;
    logic [SLW-1:0]   res_slot_reg, res_slot_next;
    logic             res_valid_reg, res_valid_next;
    logic [VW-1:0]    res_value_reg, res_value_next;
    lsa_pkg::status_t out_status_reg, out_status_next;
    logic [SLW-1:0]   out_slot_reg, out_slot_next;
    logic             out_entry_reg, out_entry_next;
    logic [VW-1:0]    out_value_reg, out_value_next;
    logic [SW-1:0]    sum_reg, sum_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    prev_idx_reg, prev_idx_next;
    logic             prev_vld_reg, prev_vld_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;

    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [VW-1:0]    ram_rdata;

    logic [VW-1:0]    now_inc;
    logic [VW-1:0]    elapsed;
    logic [AW:0]      ptr_inc;
    logic             ptr_wrap;
    logic [AW-1:0]    slot_idx;
    logic             in_range;
    logic             walk_done;
    logic             out_free;
    logic [CW:0]      div_tmp;
    logic [CW:0]      div_sub;
    logic             div_ge;

    assign now_inc   = now_reg + VW'(1);
    assign elapsed   = now_reg - start_reg;
    assign ptr_inc   = {1'b0, ptr_reg} + (AW + 1)'(1);
    assign ptr_wrap  = (ptr_inc == (AW + 1)'(SLOTS));
    assign slot_idx  = slot_reg[AW-1:0];
    assign in_range  = ({1'b0, slot_reg} < (SLW + 1)'(SLOTS));
    assign walk_done = (idx_reg == IW'(SLOTS));
    assign out_free  = !out_valid_reg || rsp_ready;

    // One restoring step of sum / count per cycle; the sum register becomes the quotient.
    assign div_tmp = {rem_reg, sum_reg[SW-1]};
    assign div_sub = div_tmp - {1'b0, cnt_reg};
    assign div_ge  = (div_tmp >= {1'b0, cnt_reg});

    assign ram_raddr = cmd.walk ? idx_reg[AW-1:0] : slot_idx;

    lsa_ram #(
        .WIDTH(VW),
        .DEPTH(SLOTS)
    ) u_lap_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ptr_reg),
        .wdata(elapsed),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        now_next        = now_reg;
        start_next      = start_reg;
        running_next    = running_reg;
        ptr_next        = ptr_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        func_next       = func_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_valid_next  = res_valid_reg;
        res_value_next  = res_value_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_entry_next  = out_entry_reg;
        out_value_next  = out_value_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        idx_next        = idx_reg;
        prev_idx_next   = prev_idx_reg;
        prev_vld_next   = prev_vld_reg;
        div_cnt_next    = div_cnt_reg;
        ram_we          = 1'b0;

        if (cmd.latch)
        begin
            func_next = lsa_pkg::func_t'(func);
            slot_next = slot;
        end

        if (cmd.exec)
        begin
            res_status_next = lsa_pkg::ST_OK;
            res_slot_next   = SLW'(ptr_reg);
            res_valid_next  = 1'b0;
            res_value_next  = '0;
            unique case (func_reg)
                lsa_pkg::FN_TICK:
                begin
                    now_next       = now_inc;
                    res_value_next = now_inc;
                end
                lsa_pkg::FN_START:
                begin
                    if (!running_reg)
                    begin
                        start_next     = now_reg;
                        running_next   = 1'b1;
                        res_value_next = now_reg;
                    end
                    else
                    begin
                        res_status_next = lsa_pkg::ST_IGNORED;
                        res_value_next  = start_reg;
                    end
                end
                lsa_pkg::FN_STOP:
                begin
                    if (running_reg)
                    begin
                        running_next        = 1'b0;
                        ram_we              = 1'b1;
                        valid_next[ptr_reg] = 1'b1;
                        res_valid_next      = 1'b1;
                        res_value_next      = elapsed;
                        ptr_next            = ptr_wrap ? '0 : ptr_inc[AW-1:0];
                    end
                    else
                    begin
                        res_status_next = lsa_pkg::ST_IGNORED;
                    end
                end
                lsa_pkg::FN_SELECT, lsa_pkg::FN_READ:
                begin
                    // In range, the memory read issued now is picked up in the next cycle.
                    res_slot_next = slot_reg;
                    if (!in_range)
                    begin
                        res_status_next = lsa_pkg::ST_BAD_SLOT;
                    end
                end
                lsa_pkg::FN_CLEAR:
                begin
                    // An invalid slot reads as zero, so the stored value need not be touched.
                    valid_next[ptr_reg] = 1'b0;
                end
                lsa_pkg::FN_AVERAGE:
                begin
                    res_slot_next = '0;
                    sum_next      = '0;
                    cnt_next      = '0;
                    rem_next      = '0;
                    idx_next      = '0;
                    prev_vld_next = 1'b0;
                    div_cnt_next  = '0;
                    if (valid_reg == '0)
                    begin
                        res_status_next = lsa_pkg::ST_NO_DATA;
                    end
                end
                default:
                begin
                    res_status_next = lsa_pkg::ST_IGNORED;
                end
            endcase
        end

        if (cmd.rd_capture)
        begin
            res_valid_next = valid_reg[slot_idx];
            res_value_next = valid_reg[slot_idx] ? ram_rdata : '0;
            if (func_reg == lsa_pkg::FN_SELECT)
            begin
                ptr_next = slot_idx;
            end
        end

        // The walk reads one slot per cycle and adds the slot read in the previous cycle.
        if (cmd.walk)
        begin
            if (prev_vld_reg && valid_reg[prev_idx_reg])
            begin
                sum_next = sum_reg + SW'(ram_rdata);
                cnt_next = cnt_reg + CW'(1);
            end
            if (!walk_done)
            begin
                prev_idx_next = idx_reg[AW-1:0];
                prev_vld_next = 1'b1;
                idx_next      = idx_reg + IW'(1);
            end
            else
            begin
                prev_vld_next = 1'b0;
            end
        end

        if (cmd.div_step)
        begin
            rem_next     = div_ge ? div_sub[CW-1:0] : div_tmp[CW-1:0];
            sum_next     = {sum_reg[SW-2:0], div_ge};
            div_cnt_next = div_cnt_reg + DCW'(1);
        end

        if (cmd.div_finish)
        begin
            res_status_next = lsa_pkg::ST_OK;
            res_value_next  = sum_reg[VW-1:0];
        end

        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_slot_next   = res_slot_reg;
            out_entry_next  = res_valid_reg;
            out_value_next  = res_value_reg;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            start_reg     <= '0;
            running_reg   <= 1'b0;
            ptr_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            now_reg       <= now_next;
            start_reg     <= start_next;
            running_reg   <= running_next;
            ptr_reg       <= ptr_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_valid_reg  <= res_valid_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_entry_reg  <= out_entry_next;
        out_value_reg  <= out_value_next;
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        rem_reg        <= rem_next;
        idx_reg        <= idx_next;
        prev_idx_reg   <= prev_idx_next;
        prev_vld_reg   <= prev_vld_next;
        div_cnt_reg    <= div_cnt_next;
    end

    assign stat.func      = func_reg;
    assign stat.in_range  = in_range;
    assign stat.any_valid = (valid_reg != '0);
    assign stat.walk_done = walk_done;
    assign stat.div_done  = (div_cnt_reg == DCW'(SW));
    assign stat.out_free  = out_free;

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_slot_out    = out_slot_reg;
    assign rsp_entry_valid = out_entry_reg;
    assign rsp_value       = out_value_reg;

    `LSA_ASSERT_ALWAYS(a_ptr_in_range, clk, rst_n, ptr_inc <= (AW + 1)'(SLOTS), "pointer out of range")
    `LSA_ASSERT_IMP(a_div_rem_below_count, clk, rst_n, cmd.div_step, rem_reg < cnt_reg, "divider remainder not below count")
    `LSA_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.load_out, out_free, "result loaded over a word not yet taken")

endmodule

`default_nettype wire

### rtl/lap_stopwatch_with_average.sv
// Top level of the lap stopwatch: controller, datapath and the two channels.
//
// Each command word on cmd gives exactly one response word on rsp. Commands are taken one
// at a time: tick, start, stop, clear, unknown codes and out-of-range slot numbers go from
// the execute state straight to the emit state, and an in-range select or read passes
// through a read-capture state between them because the lap memory has a registered read
// port. With any lap held, an average walks the lap memory through its single read port,
// one slot per cycle, and then divides with a restoring divider that produces one quotient
// bit per cycle over a (32 + clog2(SLOTS))-bit sum. A finished response waits in an
// output register, and the next command is accepted while it waits. Lap slot validity is
// held in flip-flops, so the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module lap_stopwatch_with_average #(
    parameter int SLOTS = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    lsa_cmd_if.sink      cmd,
    lsa_rsp_if.source    rsp
);

    lsa_pkg::lsa_cmd_t  ctl;
    lsa_pkg::lsa_stat_t stat;

    lsa_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .valid(cmd.valid),
        .ready(cmd.ready),
        .stat (stat),
        .cmd  (ctl)
    );

    lsa_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl),
        .stat           (stat),
        .func           (cmd.func),
        .slot           (cmd.slot),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_status     (rsp.status),
        .rsp_slot_out   (rsp.slot_out),
        .rsp_entry_valid(rsp.entry_valid),
        .rsp_value      (rsp.value)
    );

endmodule

`default_nettype wire

### test/lap_stopwatch_with_average_checker.sv
// Checker that tracks the lap stopwatch state and compares every response word it returns.
`timescale 1ns / 1ps

module lap_stopwatch_with_average_checker
    import lsa_pkg::*;
#(
    parameter int SLOTS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    lsa_cmd_if          cmd,
    lsa_rsp_if          rsp,
    output int unsigned mismatch_count,
    output int unsigned reports_pending
);

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot_out;
        logic               entry_valid;
        logic [VALUE_W-1:0] value;
    } lap_report_t;

    logic [VALUE_W-1:0] seconds;
    logic [VALUE_W-1:0] started_at;
    logic               timing;
    logic [VALUE_W-1:0] lap_time [SLOTS];
    logic               lap_held [SLOTS];
    logic [SLOT_W-1:0]  cursor;
    lap_report_t        awaited_reports [$];

    // Applies one command word to the tracked state and returns the response it must give.
    function automatic lap_report_t stopwatch_apply(input logic [FUNC_W-1:0] code,
                                                    input logic [SLOT_W-1:0] pick);
        lap_report_t               rpt;
        logic [SLOT_W-1:0]         at;
        logic [VALUE_W-1:0]        elapsed;
        logic [VALUE_W+SLOT_W-1:0] total;
        int unsigned               held;
        at = (cursor < SLOTS) ? cursor : '0;
        rpt = '{status: ST_IGNORED, slot_out: at, entry_valid: 1'b0, value: '0};
        total = '0;
        held = 0;
        case (code)
            FN_TICK:
            begin
                seconds = seconds + 1'b1;
                rpt.status = ST_OK;
                rpt.value = seconds;
            end
            FN_START:
            begin
                if (!timing)
                begin
                    started_at = seconds;
                    timing = 1'b1;
                    rpt.status = ST_OK;
                end
                rpt.value = started_at;
            end
            FN_STOP:
            begin
                if (timing)
                begin
                    // Elapsed time wraps modulo 2^32 just as the counter does.
                    elapsed = seconds - started_at;
                    timing = 1'b0;
                    lap_time[at] = elapsed;
                    lap_held[at] = 1'b1;
                    rpt = '{ST_OK, at, 1'b1, elapsed};
                    cursor = (at + 1 >= SLOTS) ? '0 : at + 1'b1;
                end
            end
            FN_SELECT, FN_READ:
            begin
                if (pick >= SLOTS)
                    rpt = '{ST_BAD_SLOT, pick, 1'b0, '0};
                else
                begin
                    if (code == FN_SELECT)
                        cursor = pick;
                    rpt = '{ST_OK, pick, lap_held[pick], lap_time[pick]};
                end
            end
            FN_CLEAR:
            begin
                lap_time[at] = '0;
                lap_held[at] = 1'b0;
                rpt.status = ST_OK;
            end
            FN_AVERAGE:
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (lap_held[k])
                    begin
                        total = total + lap_time[k];
                        held++;
                    end
                end
                rpt.slot_out = '0;
                if (held == 0)
                    rpt.status = ST_NO_DATA;
                else
                begin
                    rpt.status = ST_OK;
                    rpt.value = VALUE_W'(total / held);
                end
            end
            default:
            begin
            end
        endcase
        return rpt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lap_report_t got;
        lap_report_t want;
        if (!rst_n)
        begin
            seconds = '0;
            started_at = '0;
            timing = 1'b0;
            cursor = '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                lap_time[k] = '0;
                lap_held[k] = 1'b0;
            end
            awaited_reports.delete();
            mismatch_count = 0;
            reports_pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{status_t'(rsp.status), rsp.slot_out, rsp.entry_valid, rsp.value};
                if (awaited_reports.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: response word with none awaited: status %0d slot %0d valid %0d value %0d",
                                 $realtime, got.status, got.slot_out, got.entry_valid, got.value);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got.status !== want.status || got.slot_out !== want.slot_out ||
                        got.entry_valid !== want.entry_valid || got.value !== want.value)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("%0t: response mismatch", $realtime);
                            $display("    expected status %0d slot %0d valid %0d value %0d",
                                     want.status, want.slot_out, want.entry_valid, want.value);
                            $display("    actual   status %0d slot %0d valid %0d value %0d",
                                     got.status, got.slot_out, got.entry_valid, got.value);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                awaited_reports.push_back(stopwatch_apply(cmd.func, cmd.slot));
            reports_pending = awaited_reports.size();
        end
    end

endmodule

### test/testbench.sv
// Top of the lap stopwatch testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
    import lsa_pkg::*;

    localparam int                LAP_SLOTS    = 10;
    localparam int                RANDOM_WORDS = 950;
    localparam int                QUIET_TAIL   = 150;
    localparam logic [FUNC_W-1:0] FN_UNUSED    = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned mismatch_count;
    int unsigned reports_pending;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          words_sent = 0;

    lsa_cmd_if cmd_ch ();
    lsa_rsp_if rsp_ch ();

    lap_stopwatch_with_average #(.SLOTS(LAP_SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    lap_stopwatch_with_average_checker #(.SLOTS(LAP_SLOTS)) lap_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_ch),
        .rsp             (rsp_ch),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("lap_stopwatch_with_average regression: fail");
        $finish;
    end

    // Response side: ready drops in random bursts while stall_pct is nonzero.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [FUNC_W-1:0] code, input logic [SLOT_W-1:0] pick);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= code;
        cmd_ch.slot  <= pick;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // A well-formed lap: start, some ticks, stop, with reads and averages mixed in.
    task automatic run_lap();
        if ($urandom_range(0, 3) == 0)
            send_word(FN_SELECT, SLOT_W'($urandom_range(0, LAP_SLOTS - 1)));
        send_word(FN_START, SLOT_W'($urandom_range(0, 15)));
        repeat ($urandom_range(0, 12))
            send_word(FN_TICK, SLOT_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 4) == 0)
            send_word(FN_READ, SLOT_W'($urandom_range(0, 15)));
        send_word(FN_STOP, SLOT_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) == 0)
            send_word(FN_AVERAGE, SLOT_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 9) == 0)
            send_word(FN_CLEAR, SLOT_W'($urandom_range(0, 15)));
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 8;
            default: return 30;
        endcase
    endfunction

    initial
    begin
        int base;
        int phase;
        cmd_ch.valid = 1'b0;
        cmd_ch.func  = FN_TICK;
        cmd_ch.slot  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty memory, rejected slots and ignored commands come first.
        send_word(FN_READ, 4'd15);
        send_word(FN_SELECT, 4'd10);
        send_word(FN_AVERAGE, 4'd0);
        send_word(FN_STOP, 4'd0);
        send_word(FN_CLEAR, 4'd0);
        send_word(FN_TICK, 4'd15);
        send_word(FN_START, 4'd0);
        send_word(FN_TICK, 4'd0);
        send_word(FN_TICK, 4'd0);
        send_word(FN_START, 4'd0);
        send_word(FN_STOP, 4'd0);
        send_word(FN_UNUSED, 4'd5);
        // A lap in the last slot wraps the pointer back to slot zero.
        send_word(FN_SELECT, 4'd9);
        send_word(FN_START, 4'd0);
        send_word(FN_TICK, 4'd0);
        send_word(FN_STOP, 4'd0);
        send_word(FN_READ, 4'd9);
        send_word(FN_READ, 4'd0);
        // The mean of 2 and 1 truncates to 1.
        send_word(FN_AVERAGE, 4'd0);
        send_word(FN_SELECT, 4'd0);
        send_word(FN_CLEAR, 4'd0);
        send_word(FN_READ, 4'd0);
        send_word(FN_AVERAGE, 4'd15);
        send_word(FN_SELECT, 4'd5);
        send_word(FN_READ, 4'd10);

        base = words_sent;
        phase = -1;
        while (words_sent - base < RANDOM_WORDS)
        begin
            if (RANDOM_WORDS - (words_sent - base) <= QUIET_TAIL)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else if ((words_sent - base) / 100 != phase)
            begin
                phase = (words_sent - base) / 100;
                gap_pct = pick_pct();
                stall_pct = pick_pct();
            end
            if ($urandom_range(0, 9) < 6)
                run_lap();
            else
                send_word(FUNC_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 15)));
        end
        cmd_ch.valid <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;

        while (reports_pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatch_count == 0 && reports_pending == 0)
            $display("lap_stopwatch_with_average regression: pass");
        else
            $display("lap_stopwatch_with_average regression: fail");
        $finish;
    end

endmodule

### lap_stopwatch_with_average.f
+incdir+rtl
rtl/lsa_pkg.sv
rtl/lsa_if.sv
rtl/lsa_ram.sv
rtl/lsa_ctrl.sv
rtl/lsa_dp.sv
rtl/lap_stopwatch_with_average.sv
test/lap_stopwatch_with_average_checker.sv
test/testbench.sv
